// File: src/skts_pkg.sv
// Shared types and constants for the sorted key table search block.
// No dependencies.
`default_nettype none
package skts_pkg;

	localparam int KEY_W   = 32;
	localparam int POS_W   = 10;
	localparam int COUNT_W = 11;
	localparam int INDEX_W = 11;
	localparam int OP_W    = 2;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD    = 2'd0,
		OP_LOOKUP  = 2'd1,
		OP_ADVANCE = 2'd2
	} op_t;

	typedef struct packed {
		logic [OP_W-1:0]  operation;
		logic [KEY_W-1:0] key_value;
		logic [POS_W-1:0] position;
	} cmd_t;

	typedef struct packed {
		logic               found;
		logic [INDEX_W-1:0] result_index;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LK,
		ST_GF,
		ST_GS,
		ST_GH,
		ST_GB
	} state_t;

endpackage
`default_nettype wire

// File: src/skts_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none
module skts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: src/skts_engine.sv
// Search sequencer: load, binary lookup and galloping advance over the key RAM.
// Depends on skts_pkg; drives the ports of one skts_ram.
`default_nettype none
module skts_engine import skts_pkg::*; #(
	parameter int MAX_KEYS = 1024,
	localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1,
	localparam int XW = (AW + 2 > 12) ? AW + 2 : 12
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire cmd_t             cmd,
	input  wire logic [XW-1:0]    eff_count,
	output logic                  busy,
	output logic                  done,
	output result_t               result,
	output logic                  ram_we,
	output logic [AW-1:0]         ram_waddr,
	output logic [KEY_W-1:0]      ram_wdata,
	output logic                  ram_re,
	output logic [AW-1:0]         ram_raddr,
	input  wire logic [KEY_W-1:0] ram_rdata
);

	localparam logic [XW-1:0] MAX_X = XW'(MAX_KEYS);
	localparam logic [XW-1:0] ONE_X = XW'(1);

	state_t state_q, state_d;

	logic [XW-1:0]    lo_q, lo_d;
	logic [XW-1:0]    hi_q, hi_d;
	logic [XW-1:0]    probe_q, probe_d;
	logic [XW-1:0]    span_q, span_d;
	logic [XW-1:0]    n_q, n_d;
	logic [KEY_W-1:0] key_q, key_d;
	logic             done_q, done_d;
	result_t          res_q, res_d;

	logic          v_lt, v_eq;
	logic [XW-1:0] st_pos1, st_mid, nm1;
	logic          st_adv_run, st_lk_run, st_load_ok;
	logic [XW-1:0] lk_lo, lk_hi, lk_mid;
	logic          lk_more;
	logic [XW-1:0] gf_next, gs_span, gs_next;
	logic          gf_more, gs_more;
	logic [XW-1:0] gh_lo, gh_mid;
	logic          gh_more;
	logic [XW-1:0] gb_lo, gb_hi, gb_mid;
	logic          gb_more;

	assign v_lt = ram_rdata < key_q;
	assign v_eq = ram_rdata == key_q;

	assign st_pos1    = XW'(cmd.position) + ONE_X;
	assign st_mid     = (eff_count - ONE_X) >> 1;
	assign st_adv_run = st_pos1 < eff_count;
	assign st_lk_run  = eff_count != '0;
	assign st_load_ok = XW'(cmd.position) < MAX_X;
	assign nm1        = n_q - ONE_X;

	assign lk_lo   = v_lt ? probe_q + ONE_X : lo_q;
	assign lk_hi   = v_lt ? hi_q : probe_q;
	assign lk_more = lk_lo < lk_hi;
	assign lk_mid  = (lk_lo + lk_hi - ONE_X) >> 1;

	assign gf_next = lo_q + ONE_X;
	assign gf_more = gf_next < n_q;
	assign gs_span = span_q << 1;
	assign gs_next = lo_q + gs_span;
	assign gs_more = gs_next < n_q;

	assign gh_lo   = lo_q + (span_q >> 1);
	assign gh_more = (gh_lo + ONE_X) < hi_q;
	assign gh_mid  = (gh_lo + hi_q) >> 1;

	assign gb_lo   = v_lt ? probe_q : lo_q;
	assign gb_hi   = v_lt ? hi_q : probe_q;
	assign gb_more = (gb_lo + ONE_X) < gb_hi;
	assign gb_mid  = (gb_lo + gb_hi) >> 1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (cmd.operation)
						OP_LOOKUP:  if (st_lk_run) state_d = ST_LK;
						OP_ADVANCE: if (st_adv_run) state_d = ST_GF;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_LK: begin
				if (v_eq || !lk_more) state_d = ST_IDLE;
			end
			ST_GF: begin
				if (!v_lt) state_d = ST_IDLE;
				else if (gf_more) state_d = ST_GS;
				else state_d = ST_GH;
			end
			ST_GS: begin
				if (!v_lt || !gs_more) state_d = ST_GH;
			end
			ST_GH: begin
				if (v_eq || v_lt || !gh_more) state_d = ST_IDLE;
				else state_d = ST_GB;
			end
			ST_GB: begin
				if (v_eq || !gb_more) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		lo_d      = lo_q;
		hi_d      = hi_q;
		probe_d   = probe_q;
		span_d    = span_q;
		n_d       = n_q;
		key_d     = key_q;
		done_d    = 1'b0;
		res_d     = res_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					key_d = cmd.key_value;
					n_d   = eff_count;
					case (cmd.operation)
						OP_LOAD: begin
							ram_we = st_load_ok;
							done_d = 1'b1;
							res_d  = '0;
						end
						OP_LOOKUP: begin
							lo_d = '0;
							hi_d = eff_count;
							if (st_lk_run) begin
								probe_d = st_mid;
								ram_re  = 1'b1;
							end else begin
								done_d = 1'b1;
								res_d  = '0;
							end
						end
						OP_ADVANCE: begin
							lo_d = st_pos1;
							if (st_adv_run) begin
								probe_d = st_pos1;
								ram_re  = 1'b1;
							end else begin
								done_d = 1'b1;
								res_d  = '{found: 1'b0, result_index: st_pos1[INDEX_W-1:0]};
							end
						end
						default: begin
							done_d = 1'b1;
							res_d  = '0;
						end
					endcase
				end
			end
			ST_LK: begin
				if (v_eq) begin
					done_d = 1'b1;
					res_d  = '{found: 1'b1, result_index: probe_q[INDEX_W-1:0]};
				end else begin
					lo_d = lk_lo;
					hi_d = lk_hi;
					if (lk_more) begin
						probe_d = lk_mid;
						ram_re  = 1'b1;
					end else begin
						done_d = 1'b1;
						res_d  = '{found: 1'b0, result_index: lk_lo[INDEX_W-1:0]};
					end
				end
			end
			ST_GF: begin
				if (!v_lt) begin
					done_d = 1'b1;
					res_d  = '{found: v_eq, result_index: lo_q[INDEX_W-1:0]};
				end else begin
					span_d = ONE_X;
					ram_re = 1'b1;
					if (gf_more) begin
						probe_d = gf_next;
					end else begin
						hi_d    = nm1;
						probe_d = nm1;
					end
				end
			end
			ST_GS: begin
				ram_re = 1'b1;
				if (v_lt) begin
					span_d = gs_span;
					if (gs_more) begin
						probe_d = gs_next;
					end else begin
						hi_d    = nm1;
						probe_d = nm1;
					end
				end else begin
					hi_d = probe_q;
				end
			end
			ST_GH: begin
				if (v_eq) begin
					done_d = 1'b1;
					res_d  = '{found: 1'b1, result_index: hi_q[INDEX_W-1:0]};
				end else if (v_lt) begin
					done_d = 1'b1;
					res_d  = '{found: 1'b0, result_index: n_q[INDEX_W-1:0]};
				end else begin
					lo_d = gh_lo;
					if (gh_more) begin
						probe_d = gh_mid;
						ram_re  = 1'b1;
					end else begin
						done_d = 1'b1;
						res_d  = '{found: 1'b0, result_index: hi_q[INDEX_W-1:0]};
					end
				end
			end
			ST_GB: begin
				if (v_eq) begin
					done_d = 1'b1;
					res_d  = '{found: 1'b1, result_index: probe_q[INDEX_W-1:0]};
				end else begin
					lo_d = gb_lo;
					hi_d = gb_hi;
					if (gb_more) begin
						probe_d = gb_mid;
						ram_re  = 1'b1;
					end else begin
						done_d = 1'b1;
						res_d  = '{found: 1'b0, result_index: gb_hi[INDEX_W-1:0]};
					end
				end
			end
			default: begin
				done_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		lo_q    <= lo_d;
		hi_q    <= hi_d;
		probe_q <= probe_d;
		span_q  <= span_d;
		n_q     <= n_d;
		key_q   <= key_d;
		res_q   <= res_d;
	end

	assign busy      = state_q != ST_IDLE;
	assign done      = done_q;
	assign result    = res_q;
	assign ram_waddr = cmd.position[AW-1:0];
	assign ram_wdata = cmd.key_value;
	assign ram_raddr = probe_d[AW-1:0];

endmodule
`default_nettype wire

// File: src/sorted_key_table_search.sv
// Sorted key table search: binary lookup and galloping advance over a key RAM.
// Load writes one key; lookup binary-searches with at most log2(count)+1 probes;
// advance probes position+1, gallops with doubling spans, then binary-searches the last span.
// One item at a time, bounded by the single read port of the key RAM.
// Result strobe done is registered from the compare of the last probe's read data; busy low accepts start.
// Reset clears key_count and the sequencer; the key RAM is undefined until loaded.
`default_nettype none
module sorted_key_table_search import skts_pkg::*; #(
	parameter int MAX_KEYS = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire cmd_t               cmd,
	output logic                    busy,
	output logic                    done,
	output result_t                 result,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [COUNT_W-1:0] cfg_data
);

	localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int XW = (AW + 2 > 12) ? AW + 2 : 12;
	localparam logic [XW-1:0] MAX_X = XW'(MAX_KEYS);

	logic [COUNT_W-1:0] key_count_q;
	logic [XW-1:0]      count_x, eff_count;

	logic             ram_we, ram_re;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	logic [KEY_W-1:0] ram_wdata, ram_rdata;

	assign cfg_ready = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			key_count_q <= cfg_data;
		end
	end

	assign count_x   = XW'(key_count_q);
	assign eff_count = (count_x > MAX_X) ? MAX_X : count_x;

	skts_engine #(
		.MAX_KEYS(MAX_KEYS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.eff_count (eff_count),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	skts_ram #(
		.WIDTH(KEY_W),
		.DEPTH(MAX_KEYS)
	) u_key_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule
`default_nettype wire

// File: sim/sorted_key_table_search_tb.sv
// Self-checking testbench for sorted_key_table_search: binary lookup and galloping advance.
// Drives load, lookup and advance items plus key_count writes; a scoreboard predicts each answer.
// Depends on skts_pkg and the sorted_key_table_search RTL only.
`timescale 1ns / 1ps

module sorted_key_table_search_tb;
	import skts_pkg::*;

	localparam int TABLE_DEPTH = 1024;
	localparam int FILL_KEYS   = 256;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int MAX_REPORTS = 10;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	class key_search_scoreboard;
		logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
		int unsigned key_count;
		result_t pending_answers[$];
		int mismatches;
		int checked;
		int loads;
		int lookups;
		int advances;
		int hits;
		int count_writes;

		function int unsigned active_keys();
			return (key_count > TABLE_DEPTH) ? TABLE_DEPTH : key_count;
		endfunction

		function logic [KEY_W-1:0] read_key(int unsigned i);
			return (i < TABLE_DEPTH) ? key_mem[i] : '0;
		endfunction

		function void set_key_count(logic [COUNT_W-1:0] v);
			key_count = v;
			count_writes++;
		endfunction

		function result_t binary_lookup(logic [KEY_W-1:0] key);
			int lo;
			int hi;
			int mid;
			logic [KEY_W-1:0] v;
			result_t r;
			r = '0;
			lo = 0;
			hi = int'(active_keys()) - 1;
			while (lo <= hi) begin
				mid = (lo + hi) / 2;
				v = read_key(mid);
				if (v < key) begin
					lo = mid + 1;
				end else if (v > key) begin
					hi = mid - 1;
				end else begin
					r.found = 1'b1;
					r.result_index = INDEX_W'(mid);
					return r;
				end
			end
			r.result_index = INDEX_W'(lo);
			return r;
		endfunction

		function int unsigned gallop_from(logic [POS_W-1:0] pos, logic [KEY_W-1:0] target);
			int unsigned n;
			int unsigned lo;
			int unsigned hi;
			int unsigned span;
			int unsigned mid;
			logic [KEY_W-1:0] v;
			n = active_keys();
			lo = int'(pos) + 1;
			span = 1;
			if (lo >= n || read_key(lo) >= target)
				return lo;
			while (lo + span < n && read_key(lo + span) < target)
				span = span << 1;
			hi = (lo + span < n) ? lo + span : n - 1;
			if (read_key(hi) == target)
				return hi;
			if (read_key(hi) < target)
				return n;
			lo = lo + (span >> 1);
			while (lo + 1 < hi) begin
				mid = (lo + hi) >> 1;
				v = read_key(mid);
				if (v == target)
					return mid;
				if (v < target)
					lo = mid;
				else
					hi = mid;
			end
			return hi;
		endfunction

		function void note_item(cmd_t c);
			result_t r;
			int unsigned idx;
			r = '0;
			case (c.operation)
				OP_LOAD: begin
					if (c.position < TABLE_DEPTH)
						key_mem[c.position] = c.key_value;
					loads++;
				end
				OP_LOOKUP: begin
					r = binary_lookup(c.key_value);
					lookups++;
				end
				OP_ADVANCE: begin
					idx = gallop_from(c.position, c.key_value);
					r.result_index = INDEX_W'(idx);
					r.found = (idx < active_keys() && read_key(idx) == c.key_value);
					advances++;
				end
				default: ;
			endcase
			if (r.found)
				hits++;
			pending_answers.push_back(r);
		endfunction

		function void check_answer(result_t got);
			result_t want;
			if (pending_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: found=%0d index=%0d", got.found,
						got.result_index);
				return;
			end
			want = pending_answers.pop_front();
			checked++;
			if (got.found !== want.found || got.result_index !== want.result_index) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("result %0d: expected found=%0d index=%0d, got %0d %0d",
						checked, want.found, want.result_index, got.found,
						got.result_index);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	cmd_t cmd;
	logic busy;
	logic done;
	result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [COUNT_W-1:0] cfg_data;

	key_search_scoreboard sb = new();
	int sender_idle_pct = 17;
	int cycle_count = 0;

	sorted_key_table_search #(.MAX_KEYS(TABLE_DEPTH)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_answer(result);
	end

	function automatic cmd_t make_item(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
			logic [POS_W-1:0] pos);
		cmd_t c;
		c.operation = op;
		c.key_value = key;
		c.position = pos;
		return c;
	endfunction

	function automatic logic [KEY_W-1:0] pick_target(int unsigned n, int unsigned first);
		int unsigned roll;
		int unsigned idx;
		logic [KEY_W-1:0] k;
		roll = $urandom_range(99);
		if (n == 0 || roll >= 80) begin
			case ($urandom_range(2))
				0: return '0;
				1: return '1;
				default: return $urandom();
			endcase
		end
		if (first >= n)
			first = 0;
		idx = $urandom_range(n - 1, first);
		k = sb.key_mem[idx];
		if (roll < 45)
			return k;
		if (roll < 62)
			return k + 1;
		return k - 1;
	endfunction

	function automatic logic [KEY_W-1:0] load_value(int unsigned pos);
		longint lo_b;
		longint hi_b;
		if ($urandom_range(99) < 4)
			return $urandom();
		lo_b = (pos > 0) ? longint'(sb.key_mem[pos - 1]) + 1 : 0;
		hi_b = (pos < FILL_KEYS - 1) ? longint'(sb.key_mem[pos + 1]) - 1 : 64'hFFFF_FFFF;
		if (lo_b > hi_b)
			return sb.key_mem[pos];
		return KEY_W'(lo_b + longint'($urandom_range(int'(hi_b - lo_b))));
	endfunction

	function automatic cmd_t random_item(int unsigned n);
		cmd_t c;
		int unsigned roll;
		int unsigned pos;
		roll = $urandom_range(99);
		pos = $urandom_range(TABLE_DEPTH - 1);
		if (roll < 40) begin
			c = make_item(OP_LOOKUP, pick_target(n, 0), POS_W'(pos));
		end else if (roll < 80) begin
			roll = $urandom_range(99);
			if (n > 0 && roll < 70)
				pos = $urandom_range(n - 1);
			else if (n >= 2 && roll < 85)
				pos = n - 2 + $urandom_range(2);
			if (pos > TABLE_DEPTH - 1)
				pos = TABLE_DEPTH - 1;
			c = make_item(OP_ADVANCE, pick_target(n, pos + 1), POS_W'(pos));
		end else if (roll < 96) begin
			pos = $urandom_range(FILL_KEYS - 1);
			c = make_item(OP_LOAD, load_value(pos), POS_W'(pos));
		end else begin
			c = make_item(OP_UNUSED, $urandom(), POS_W'(pos));
		end
		return c;
	endfunction

	task automatic send_item(input cmd_t c);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < sender_idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_item(c);
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		do
			@(negedge clk);
		while (sb.pending_answers.size() != 0 || busy);
	endtask

	task automatic write_key_count(input logic [COUNT_W-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_key_count(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int unsigned counts[9];
		logic [KEY_W-1:0] k;
		start = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty table: searches must not touch the key store
		write_key_count(COUNT_W'(0));
		send_item(make_item(OP_LOOKUP, '0, '0));
		send_item(make_item(OP_LOOKUP, '1, '1));
		send_item(make_item(OP_ADVANCE, '0, '0));
		send_item(make_item(OP_ADVANCE, '1, '1));
		send_item(make_item(OP_UNUSED, '1, '1));

		// fill the low part of the table in increasing order, zero first, all ones last
		k = '0;
		for (int i = 0; i < FILL_KEYS; i++) begin
			if (i == FILL_KEYS - 1)
				k = '1;
			else if (i > 0)
				k = k + $urandom_range(4_000_000, 1);
			send_item(make_item(OP_LOAD, k, POS_W'(i)));
		end
		send_item(make_item(OP_LOAD, '1, POS_W'(TABLE_DEPTH - 1)));

		write_key_count(COUNT_W'(FILL_KEYS));
		send_item(make_item(OP_LOOKUP, '0, '0));
		send_item(make_item(OP_LOOKUP, '1, '0));
		send_item(make_item(OP_LOOKUP, sb.key_mem[128] + 1, '0));
		send_item(make_item(OP_ADVANCE, sb.key_mem[1], POS_W'(0)));
		send_item(make_item(OP_ADVANCE, '0, POS_W'(0)));
		send_item(make_item(OP_ADVANCE, sb.key_mem[200], POS_W'(3)));
		send_item(make_item(OP_ADVANCE, sb.key_mem[200] + 1, POS_W'(3)));
		send_item(make_item(OP_ADVANCE, '1, POS_W'(FILL_KEYS - 2)));
		send_item(make_item(OP_ADVANCE, '0, POS_W'(FILL_KEYS - 1)));
		send_item(make_item(OP_ADVANCE, sb.key_mem[50], POS_W'(100)));
		send_item(make_item(OP_UNUSED, '0, '0));

		// oversized counts: probe only the top entry
		write_key_count(COUNT_W'(2047));
		send_item(make_item(OP_ADVANCE, '0, POS_W'(TABLE_DEPTH - 2)));
		send_item(make_item(OP_ADVANCE, '1, POS_W'(TABLE_DEPTH - 2)));
		send_item(make_item(OP_ADVANCE, '1, POS_W'(TABLE_DEPTH - 1)));
		write_key_count(COUNT_W'(TABLE_DEPTH + 1));
		send_item(make_item(OP_ADVANCE, '1, POS_W'(TABLE_DEPTH - 2)));
		write_key_count(COUNT_W'(TABLE_DEPTH));
		send_item(make_item(OP_ADVANCE, '0, POS_W'(TABLE_DEPTH - 1)));

		counts = '{FILL_KEYS, 1, 2, 3, 4 + $urandom_range(60), FILL_KEYS, FILL_KEYS - 1,
			$urandom_range(FILL_KEYS - 1, 65), FILL_KEYS};
		for (int p = 0; p < 9; p++) begin
			write_key_count(COUNT_W'(counts[p]));
			sender_idle_pct = (p < 3) ? 17 : (p < 6) ? 88 : 0;
			repeat (25)
				send_item(random_item(sb.active_keys()));
		end

		drain();
		repeat (40) @(posedge clk);
		if (sb.pending_answers.size() != 0) begin
			$display("%0d expected results never arrived", sb.pending_answers.size());
			sb.mismatches += sb.pending_answers.size();
		end
		$display("ran %0d loads, %0d lookups, %0d advances (%0d found)",
			sb.loads, sb.lookups, sb.advances, sb.hits);
		$display("over %0d key_count settings; checked %0d results, %0d mismatches",
			sb.count_writes, sb.checked, sb.mismatches);
		if (sb.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
